// ===== hdl/fir32_pkg.sv =====
// shared constants and coefficient table for the 32-tap fir filter
// no dependencies; used by fir32_cell and fir_filter_32_tap_fixed_core
package fir32_pkg;

   localparam int TAP_COUNT_DEF   = 32;
   localparam int SAMPLE_BITS_DEF = 12;
   localparam int COEF_LEN        = 32;
   localparam int COEF_BITS       = 16;
   localparam int ACC_BITS        = 32;
   localparam int OUT_SHIFT       = 16;
   localparam int OUT_BITS        = 16;

   typedef logic signed [COEF_BITS-1:0] coef_type;
   typedef logic [ACC_BITS-1:0]         acc_type;

   localparam coef_type COEF_TABLE [COEF_LEN] = '{
      -16'sd5197, -16'sd881,   16'sd412,   16'sd2283,  16'sd4000,  16'sd4783,
       16'sd4082,  16'sd1907, -16'sd1131, -16'sd3979, -16'sd5542, -16'sd5122,
      -16'sd2738,  16'sd838,   16'sd4338,  16'sd6485,  16'sd6485,  16'sd4338,
       16'sd838,  -16'sd2738, -16'sd5122, -16'sd5542, -16'sd3979, -16'sd1131,
       16'sd1907,  16'sd4082,  16'sd4783,  16'sd4000,  16'sd2283,  16'sd412,
      -16'sd881,  -16'sd5197
   };

   // taps past the end of the table have a zero coefficient
   function automatic coef_type coef_at(input int k);
      coef_type c;
      c = '0;
      if (k < COEF_LEN) begin
         c = COEF_TABLE[k];
      end
      return c;
   endfunction

endpackage

// ===== hdl/fir_filter_32_tap_fixed_core.sv =====
// top level of the 32-tap fixed-coefficient fir filter
// depends on fir32_pkg and fir32_cell
//
// usage:
//   input channel req_valid / req_stall / req_sample carries one unsigned adc
//   sample per word; result channel rsp_valid / rsp_stall / rsp_filtered carries
//   one signed 16-bit filter output per word (bits 31..16 of the 32-bit sum).
//   the filter is in transposed form: a row of TAP_COUNT cells, each multiplying
//   the new sample by its fixed coefficient and adding the partial sum of its
//   neighbor. cell 0 holds the finished sum, which is the output register.
// output: a result is valid in the cycle after its sample is taken.
// throughput: one sample per clock, sustained while rsp_stall stays low; the cycle time is set by one
//   16x13 constant multiply and one 32-bit add inside each cell.
// reset: all partial sums clear, which is the same as an all-zero sample
//   history; the result register is empty after reset.
// stall: while a result waits with rsp_stall high, req_stall is raised and the
//   whole chain holds; once the result is taken a new sample can enter in the
//   same cycle.
module fir_filter_32_tap_fixed_core
   import fir32_pkg::*;
#(
   parameter int TAP_COUNT   = TAP_COUNT_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [OUT_BITS-1:0]    rsp_filtered
);

   logic    advance;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   acc_type part [0:TAP_COUNT];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign advance   = req_valid && !req_stall;

   // the last cell has no neighbor behind it
   assign part[TAP_COUNT] = '0;

   generate
      for (genvar k = 0; k < TAP_COUNT; k++) begin : g_tap
         fir32_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .COEF_VAL    (coef_at(k))
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .advance  (advance),
            .sample   (req_sample),
            .part_in  (part[k+1]),
            .part_out (part[k])
         );
      end
   endgenerate

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = part[0][OUT_SHIFT +: OUT_BITS];

`ifndef SYNTH
   // the input side only waits on a full, stalled result register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a pending result");

   // every taken sample produces a result in the next cycle
   a_accept_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted sample gave no result");

   // a drained result with no new sample leaves the register empty
   a_drain_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !req_valid) |=> !rsp_valid)
      else $error("result repeated after being taken");

   // result register is empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // the output sum holds while the chain does not advance
   a_hold_sum: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(rsp_filtered))
      else $error("stalled result changed");
`endif

endmodule

// ===== hdl/fir32_cell.sv =====
// one tap of the transposed fir chain: constant multiply, add, partial sum register
// depends on fir32_pkg
module fir32_cell
   import fir32_pkg::*;
#(
   parameter int       SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter coef_type COEF_VAL    = '0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  acc_type                part_in,
   output acc_type                part_out
);

   localparam int PROD_BITS = COEF_BITS + SAMPLE_BITS + 1;

   logic signed [SAMPLE_BITS:0]   sample_s;
   logic signed [PROD_BITS-1:0]   prod;
   acc_type                       prod_ext;
   acc_type                       part_ff;
   acc_type                       part_in_sum;

   assign sample_s = signed'({1'b0, sample});
   assign prod     = COEF_VAL * sample_s;

   generate
      if (PROD_BITS >= ACC_BITS) begin : g_trunc
         assign prod_ext = prod[ACC_BITS-1:0];
      end else begin : g_sext
         assign prod_ext = {{(ACC_BITS-PROD_BITS){prod[PROD_BITS-1]}}, prod};
      end
   endgenerate

   // accumulator wraps modulo 2^32
   assign part_in_sum = prod_ext + part_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         part_ff <= '0;
      end else if (advance) begin
         part_ff <= part_in_sum;
      end
   end

   assign part_out = part_ff;

endmodule
